// File: rtl/label_mark_table_unit_assert.svh
// ----------------------------------------------------------------------------
// Label mark table assertion macros
// Immediate-consequence and next-cycle property macros clocked on clk.
// ----------------------------------------------------------------------------
`ifndef LABEL_MARK_TABLE_UNIT_ASSERT_SVH
`define LABEL_MARK_TABLE_UNIT_ASSERT_SVH

`define LMT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define LMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lmt_pkg.sv
// ----------------------------------------------------------------------------
// Label mark table package
// Shared types and constants for the label mark table cells and control.
// ----------------------------------------------------------------------------
package lmt_pkg;

  localparam int DEFAULT_ENTRIES = 64;

  localparam logic signed [16:0] NO_LINE = -17'sd1;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_FIND  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_RANGE = 2'd3
  } lmt_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } lmt_state_t;

  typedef struct packed {
    lmt_kind_t   kind;
    logic [15:0] mark_name;
    logic [15:0] line_number;
    logic        up_direction;
    logic [15:0] dest_line;
  } lmt_in_t;

  typedef struct packed {
    logic signed [16:0] found_line;
    logic               in_range;
    logic               table_full;
  } lmt_out_t;

  typedef struct packed {
    logic        we;
    logic [15:0] name;
    logic [15:0] line;
  } lmt_wr_t;

  typedef struct packed {
    logic        valid;
    logic        range_op;
    logic        up;
    logic [15:0] name;
    logic [15:0] ref_line;
    logic [15:0] hi_line;
    logic        hit;
    logic [15:0] best;
  } lmt_tok_t;

endpackage

// File: rtl/label_mark_table_unit.sv
// ----------------------------------------------------------------------------
// Label mark table unit
// Table of label marks held in a chain of cells, one mark per cell, with
// add, find, clear and range check transactions.
// ----------------------------------------------------------------------------
//   Channel | Ports                        | Payload
//   input   | in_valid, in_stall, in_data  | kind, name, line, direction, dest
//   output  | out_valid, out_stall, out_data | found line, in range, table full
//
// An add or a clear does not stall the input unless its result has to be held.
// A find or a range check sends a token down the chain of ENTRIES cells, one
// cell per cycle, and the input stalls until the token leaves the last cell.
// Reset empties the table and clears the search tokens and the result valid flag.
// A stalled result waits in a hold register; the input stalls meanwhile.
`include "label_mark_table_unit_assert.svh"

module label_mark_table_unit #(
  parameter int ENTRIES = lmt_pkg::DEFAULT_ENTRIES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lmt_pkg::lmt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lmt_pkg::lmt_out_t out_data
);
  import lmt_pkg::*;

  localparam int FW = $clog2(ENTRIES + 1);

  lmt_wr_t       wr;
  logic [FW-1:0] fill;
  lmt_tok_t      tok [0:ENTRIES];

  lmt_ctrl #(
    .ENTRIES(ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .wr       (wr),
    .fill     (fill),
    .launch   (tok[0]),
    .tail     (tok[ENTRIES])
  );

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lmt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .wr     (wr),
      .wr_sel (fill == FW'(i)),
      .slot_ok(FW'(i) < fill),
      .tok_in (tok[i]),
      .tok_out(tok[i+1])
    );
  end

  `LMT_ASSERT_NOW(a_fill_bound, 1'b1, fill <= FW'(ENTRIES), "Fill level exceeds the table size.")
  `LMT_ASSERT_NOW(a_tail_while_busy, tok[ENTRIES].valid, in_stall, "Token left the chain while idle.")
  `LMT_ASSERT_NEXT(a_search_busy, in_valid && !in_stall && (in_data.kind == KIND_FIND || in_data.kind == KIND_RANGE), in_stall, "Search did not block the input.")
  `LMT_ASSERT_NOW(a_full_only_add, out_valid && out_data.table_full, out_data.found_line == NO_LINE && !out_data.in_range, "Full flag mixed with a search result.")

endmodule

// File: rtl/lmt_cell.sv
// ----------------------------------------------------------------------------
// Label mark table cell
// Holds one mark and updates the search token that passes through it.
// ----------------------------------------------------------------------------
module lmt_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  lmt_pkg::lmt_wr_t  wr,
  input  logic             wr_sel,
  input  logic             slot_ok,
  input  lmt_pkg::lmt_tok_t tok_in,
  output lmt_pkg::lmt_tok_t tok_out
);
  import lmt_pkg::*;

  logic [15:0] name_r;
  logic [15:0] line_r;
  lmt_tok_t    tok_r;
  lmt_tok_t    tok_nxt;

  always_ff @(posedge clk) begin
    if (wr.we && wr_sel) begin
      name_r <= wr.name;
      line_r <= wr.line;
    end
  end

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.range_op) begin
      if (slot_ok && line_r >= tok_in.ref_line && line_r < tok_in.hi_line) begin
        tok_nxt.hit = 1'b1;
      end
    end else if (slot_ok && name_r == tok_in.name) begin
      if (tok_in.up) begin
        if (line_r <= tok_in.ref_line && (!tok_in.hit || line_r > tok_in.best)) begin
          tok_nxt.hit  = 1'b1;
          tok_nxt.best = line_r;
        end
      end else begin
        if (line_r > tok_in.ref_line && (!tok_in.hit || line_r < tok_in.best)) begin
          tok_nxt.hit  = 1'b1;
          tok_nxt.best = line_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// File: rtl/lmt_ctrl.sv
// ----------------------------------------------------------------------------
// Label mark table control
// Accepts transactions, keeps the fill level, launches search tokens into the
// cell chain and holds the result register.
// ----------------------------------------------------------------------------
module lmt_ctrl #(
  parameter int ENTRIES = lmt_pkg::DEFAULT_ENTRIES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  lmt_pkg::lmt_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output lmt_pkg::lmt_out_t                out_data,
  output lmt_pkg::lmt_wr_t                 wr,
  output logic [$clog2(ENTRIES+1)-1:0]     fill,
  output lmt_pkg::lmt_tok_t                launch,
  input  lmt_pkg::lmt_tok_t                tail
);
  import lmt_pkg::*;

  localparam int FW = $clog2(ENTRIES + 1);

  lmt_state_t  state_r, state_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  lmt_out_t    hold_r, hold_nxt;
  lmt_out_t    out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;
  lmt_out_t    res;
  logic        res_valid;
  logic        out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    hold_nxt      = hold_r;
    out_nxt       = out_r;
    out_free      = !out_valid_r || !out_stall;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = (state_r != ST_IDLE);
    wr            = '0;
    launch        = '0;
    res_valid     = 1'b0;
    res.found_line = NO_LINE;
    res.in_range   = 1'b0;
    res.table_full = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.kind)
            KIND_ADD: begin
              res_valid = 1'b1;
              if (fill_r < FW'(ENTRIES)) begin
                wr.we    = 1'b1;
                wr.name  = in_data.mark_name;
                wr.line  = in_data.line_number;
                fill_nxt = fill_r + FW'(1);
              end else begin
                res.table_full = 1'b1;
              end
            end
            KIND_CLEAR: begin
              res_valid = 1'b1;
              fill_nxt  = '0;
            end
            KIND_FIND: begin
              launch.valid    = 1'b1;
              launch.up       = in_data.up_direction;
              launch.name     = in_data.mark_name;
              launch.ref_line = in_data.line_number;
              state_nxt       = ST_SCAN;
            end
            KIND_RANGE: begin
              launch.valid    = 1'b1;
              launch.range_op = 1'b1;
              if (in_data.line_number < in_data.dest_line) begin
                launch.ref_line = in_data.line_number;
                launch.hi_line  = in_data.dest_line;
              end else begin
                launch.ref_line = in_data.dest_line;
                launch.hi_line  = in_data.line_number;
              end
              state_nxt = ST_SCAN;
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (tail.valid) begin
          res_valid = 1'b1;
          if (tail.range_op) begin
            res.in_range = tail.hit;
          end else if (tail.hit) begin
            res.found_line = signed'({1'b0, tail.best});
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_nxt       = hold_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (res_valid) begin
      if (out_free) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end else begin
        hold_nxt  = res;
        state_nxt = ST_HOLD;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign fill      = fill_r;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Label mark table unit testbench
// Sends add, find, clear and range check transactions in random bursts while
// the result side stalls on its own pattern, and compares every result with
// a behavioral copy of the mark table kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import lmt_pkg::*;

  localparam int TABLE_SLOTS = DEFAULT_ENTRIES;
  localparam int RANDOM_ITEMS = 500;
  localparam int DRAIN_CYCLES = 2 * TABLE_SLOTS + 16;
  localparam int LIMIT_NS = 2_000_000;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  lmt_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lmt_out_t out_data;

  logic [15:0] mark_names [TABLE_SLOTS];
  logic [15:0] mark_lines [TABLE_SLOTS];
  int marks_held = 0;
  lmt_out_t awaited_answers [$];
  int mismatches = 0;
  int burst_left = 1;
  stall_mode_t stall_mode = STALL_NONE;
  int stall_mode_left = 0;
  int stall_phase = 0;

  label_mark_table_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  function automatic lmt_out_t table_answer(lmt_in_t item);
    lmt_out_t ans;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] best;
    logic hit;
    ans.found_line = NO_LINE;
    ans.in_range = 1'b0;
    ans.table_full = 1'b0;
    hit = 1'b0;
    best = '0;
    lo = (item.line_number < item.dest_line) ? item.line_number : item.dest_line;
    hi = (item.line_number < item.dest_line) ? item.dest_line : item.line_number;
    case (item.kind)
      KIND_ADD: begin
        if (marks_held < TABLE_SLOTS) begin
          mark_names[marks_held] = item.mark_name;
          mark_lines[marks_held] = item.line_number;
          marks_held++;
        end else begin
          ans.table_full = 1'b1;
        end
      end
      KIND_FIND: begin
        for (int i = 0; i < marks_held; i++) begin
          if (mark_names[i] == item.mark_name) begin
            if (item.up_direction) begin
              if (mark_lines[i] <= item.line_number && (!hit || mark_lines[i] > best)) begin
                best = mark_lines[i];
                hit = 1'b1;
              end
            end else if (mark_lines[i] > item.line_number && (!hit || mark_lines[i] < best)) begin
              best = mark_lines[i];
              hit = 1'b1;
            end
          end
        end
        if (hit) begin
          ans.found_line = {1'b0, best};
        end
      end
      KIND_CLEAR: begin
        marks_held = 0;
      end
      default: begin
        for (int i = 0; i < marks_held; i++) begin
          if (mark_lines[i] >= lo && mark_lines[i] < hi) begin
            ans.in_range = 1'b1;
          end
        end
      end
    endcase
    return ans;
  endfunction

  function automatic lmt_in_t make_item(lmt_kind_t kind, logic [15:0] name,
                                        logic [15:0] line, logic up, logic [15:0] dest);
    lmt_in_t item;
    item.kind = kind;
    item.mark_name = name;
    item.line_number = line;
    item.up_direction = up;
    item.dest_line = dest;
    return item;
  endfunction

  function automatic logic [15:0] near_line(logic [15:0] lines [$]);
    logic [15:0] base;
    if (lines.size() == 0 || $urandom_range(0, 3) == 0) begin
      return 16'($urandom);
    end
    base = lines[$urandom_range(0, lines.size() - 1)];
    return 16'(base + $urandom_range(0, 2) - 1);
  endfunction

  task automatic send_item(input lmt_in_t item);
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    awaited_answers.push_back(table_answer(item));
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic check_answer(input lmt_out_t got);
    lmt_out_t want;
    if (awaited_answers.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: unexpected result found_line %0d in_range %0b table_full %0b",
                 $realtime, got.found_line, got.in_range, got.table_full);
      end
    end else begin
      want = awaited_answers.pop_front();
      if (got.found_line !== want.found_line || got.in_range !== want.in_range ||
          got.table_full !== want.table_full) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: expected found_line %0d in_range %0b table_full %0b",
                   $realtime, want.found_line, want.in_range, want.table_full);
          $display("%0t: actual   found_line %0d in_range %0b table_full %0b",
                   $realtime, got.found_line, got.in_range, got.table_full);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      check_answer(out_data);
    end
    if (stall_mode_left <= 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_mode_left = $urandom_range(32, 256);
    end
    stall_mode_left--;
    stall_phase = (stall_phase + 1) % 7;
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_phase < 3);
    endcase
  end

  task automatic test_directed_cases;
    logic [15:0] name;
    name = 16'h1234;
    send_item(make_item(KIND_FIND, name, 16'hFFFF, 1'b1, 16'h0000));
    send_item(make_item(KIND_FIND, name, 16'h0000, 1'b0, 16'h0000));
    send_item(make_item(KIND_RANGE, 16'h0000, 16'h0000, 1'b0, 16'hFFFF));
    send_item(make_item(KIND_ADD, 16'h0000, 16'h0000, 1'b0, 16'h0000));
    send_item(make_item(KIND_ADD, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF));
    send_item(make_item(KIND_ADD, name, 16'd100, 1'b0, 16'h0000));
    send_item(make_item(KIND_ADD, name, 16'd100, 1'b0, 16'h0000));
    send_item(make_item(KIND_ADD, name, 16'd50, 1'b0, 16'h0000));
    send_item(make_item(KIND_ADD, name, 16'd200, 1'b0, 16'h0000));
    send_item(make_item(KIND_FIND, name, 16'd100, 1'b1, 16'h0000));
    send_item(make_item(KIND_FIND, name, 16'd99, 1'b1, 16'h0000));
    send_item(make_item(KIND_FIND, name, 16'd49, 1'b1, 16'h0000));
    send_item(make_item(KIND_FIND, name, 16'd100, 1'b0, 16'h0000));
    send_item(make_item(KIND_FIND, name, 16'd200, 1'b0, 16'h0000));
    send_item(make_item(KIND_FIND, name, 16'd0, 1'b0, 16'h0000));
    send_item(make_item(KIND_FIND, 16'h0000, 16'h0000, 1'b1, 16'h0000));
    send_item(make_item(KIND_FIND, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000));
    send_item(make_item(KIND_FIND, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000));
    send_item(make_item(KIND_RANGE, 16'h0000, 16'd100, 1'b0, 16'd100));
    send_item(make_item(KIND_RANGE, 16'h0000, 16'd200, 1'b0, 16'd100));
    send_item(make_item(KIND_RANGE, 16'h0000, 16'd201, 1'b0, 16'd200));
    send_item(make_item(KIND_RANGE, 16'h0000, 16'hFFFF, 1'b0, 16'h0000));
    send_item(make_item(KIND_RANGE, 16'h0000, 16'd201, 1'b0, 16'hFFFF));
    send_item(make_item(KIND_CLEAR, 16'h0000, 16'h0000, 1'b0, 16'h0000));
    send_item(make_item(KIND_FIND, name, 16'd100, 1'b1, 16'h0000));
  endtask

  task automatic test_full_table;
    logic [15:0] name;
    name = 16'($urandom);
    send_item(make_item(KIND_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom), 16'($urandom)));
    for (int i = 0; i < TABLE_SLOTS + 2; i++) begin
      send_item(make_item(KIND_ADD, (i % 2 == 1) ? name : 16'($urandom), 16'($urandom),
                          1'($urandom), 16'($urandom)));
    end
    send_item(make_item(KIND_FIND, name, 16'hFFFF, 1'b1, 16'($urandom)));
    send_item(make_item(KIND_FIND, name, 16'h0000, 1'b0, 16'($urandom)));
    send_item(make_item(KIND_RANGE, name, 16'h0000, 1'b0, 16'hFFFF));
    send_item(make_item(KIND_CLEAR, name, 16'h0000, 1'b0, 16'h0000));
  endtask

  task automatic test_random_sequences;
    logic [15:0] pool [4];
    logic [15:0] added [$];
    lmt_in_t item;
    int sent;
    int pick;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      foreach (pool[p]) begin
        pool[p] = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
      end
      added.delete();
      if (marks_held > TABLE_SLOTS - 8 && $urandom_range(0, 1) == 1) begin
        send_item(make_item(KIND_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom),
                            16'($urandom)));
        sent++;
      end
      repeat ($urandom_range(1, 20)) begin
        pick = $urandom_range(0, 7);
        item = make_item(KIND_ADD, pool[$urandom_range(0, 3)],
                         (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom),
                         1'($urandom), 16'($urandom));
        added.push_back(item.line_number);
        send_item(item);
        sent++;
      end
      repeat ($urandom_range(2, 12)) begin
        item = make_item(lmt_kind_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                         1'($urandom), 16'($urandom));
        pick = $urandom_range(0, 9);
        if (pick >= 2 && pick <= 6) begin
          item.kind = KIND_FIND;
          item.mark_name = pool[$urandom_range(0, 3)];
          item.line_number = near_line(added);
        end else if (pick >= 7) begin
          item.kind = KIND_RANGE;
          item.line_number = near_line(added);
          item.dest_line = near_line(added);
        end
        send_item(item);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_full_table();
    test_random_sequences();
    in_valid <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_answers.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/lmt_pkg.sv
rtl/lmt_cell.sv
rtl/lmt_ctrl.sv
rtl/label_mark_table_unit.sv
dv/tb_top.sv
